// ===== rtl/kmhrb_pkg.sv =====
`default_nettype none

package kmhrb_pkg;

    // Fixed widths of the stream fields.
    localparam int ROW_FIELD_W    = 3;
    localparam int LEVEL_FIELD_W  = 19;
    localparam int COLUMN_FIELD_W = 5;
    localparam int CODE_W         = 8;
    localparam int OUT_SLOTS      = 6;

    // Key code decoding.
    localparam logic [CODE_W-1:0] MOD_FLAG       = 8'h80;
    localparam logic [3:0]        MOD_INDEX_MASK = 4'hF;
    localparam logic [CODE_W-1:0] CODE_EMPTY     = 8'h00;

    // Operation carried in s_tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_CHECK,
        ST_KEY_READ,
        ST_SLOT_SCAN,
        ST_FINISH
    } kmhrb_state_t;

endpackage

`default_nettype wire

// ===== rtl/kmhrb_ram.sv =====
`default_nettype none

module kmhrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 114,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/key_matrix_hid_report_builder.sv =====
`default_nettype none

// Keyboard matrix scanner that maintains a boot-protocol keyboard report.
// Input stream (s_*): s_tuser selects the operation. A load transfer writes
// one key map entry; a scan transfer carries one row's active-low column
// levels. Every input transfer produces exactly one output transfer (m_*)
// holding the report after the item plus the per-row flags.
// One shared compare unit walks the columns one per cycle, pausing at each
// changed key for a key map read and, for a changed ordinary key, to walk the
// report slots one per cycle up to the first slot holding the code or the last
// slot. A load, or a scan of a row outside the matrix, goes from idle straight
// to the finish state, which writes the result register once the output
// register is free. A scan of a valid row reaches that state after its last
// column. s_tready is high only while the sequencer is idle, so a new item is
// taken only once the last one has been written to the output register.
// The result sits in an output register. While it waits, one more item is
// accepted and processed, after which the sequencer holds and s_tready stays
// low until the receiver has taken the previous result.
// Reset clears the pressed map, the modifier byte and all slots. The key map
// is not cleared and must be loaded before its entries are scanned.
module key_matrix_hid_report_builder #(
    parameter int ROW_COUNT    = 6,
    parameter int COLUMN_COUNT = 19,
    parameter int SLOT_COUNT   = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata from bit 0: row_index[2:0], column_levels[21:3],
    // map_column[26:22], map_code[34:27], zero padding[39:35]
    input  wire logic [39:0] s_tdata,
    // s_tuser: operation[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata from bit 0: report_changed[0], modifier_bits[8:1],
    // slot_code_0[16:9], slot_code_1[24:17], slot_code_2[32:25],
    // slot_code_3[40:33], slot_code_4[48:41], slot_code_5[56:49],
    // rollover_overflow[57], inconsistency_seen[58], zero padding[63:59]
    output logic      [63:0] m_tdata
);

    import kmhrb_pkg::*;

    // Columns beyond the level field are never scanned.
    localparam int SCAN_COLS = (COLUMN_COUNT < LEVEL_FIELD_W) ? COLUMN_COUNT : LEVEL_FIELD_W;
    localparam int COL_W     = (SCAN_COLS > 1) ? $clog2(SCAN_COLS) : 1;
    localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MAP_DEPTH = ROW_COUNT * COLUMN_COUNT;
    localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    // Input fields.
    logic                      in_op;
    logic [ROW_FIELD_W-1:0]    in_row;
    logic [LEVEL_FIELD_W-1:0]  in_levels;
    logic [COLUMN_FIELD_W-1:0] in_column;
    logic [CODE_W-1:0]         in_code;

    assign in_op     = s_tuser;
    assign in_row    = s_tdata[2:0];
    assign in_levels = s_tdata[21:3];
    assign in_column = s_tdata[26:22];
    assign in_code   = s_tdata[34:27];

    kmhrb_state_t state_reg, state_next;

    logic [SCAN_COLS-1:0] pressed_reg [ROW_COUNT];
    logic [SCAN_COLS-1:0] pressed_next [ROW_COUNT];
    logic [CODE_W-1:0]    slot_reg [SLOT_COUNT];
    logic [CODE_W-1:0]    slot_next [SLOT_COUNT];
    logic [CODE_W-1:0]    modifier_reg, modifier_next;

    logic [ROW_W-1:0]     row_reg, row_next;
    logic [SCAN_COLS-1:0] levels_reg, levels_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic                 down_reg, down_next;
    logic [SLOT_W-1:0]    slot_idx_reg, slot_idx_next;
    logic [SLOT_W-1:0]    free_idx_reg, free_idx_next;
    logic                 free_found_reg, free_found_next;
    logic                 changed_reg, changed_next;
    logic                 overflow_reg, overflow_next;
    logic                 incons_reg, incons_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [63:0]          m_tdata_reg, m_tdata_next;

    // Decode signals for the sequencer, the datapath and the key map write.
    logic                 accept;
    logic                 row_ok;
    logic                 column_ok;
    logic                 toggle;
    logic                 last_col;
    logic                 last_slot;
    logic                 key_is_slot;
    logic                 slot_hit;
    logic                 slot_done;
    logic                 out_free;
    logic [CODE_W-1:0]    cur_slot;

    logic                 map_wr_en;
    logic [ADDR_W-1:0]    map_wr_addr;
    logic [ADDR_W-1:0]    map_rd_addr;
    logic [CODE_W-1:0]    map_rd_data;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign row_ok    = (32'(in_row) < ROW_COUNT);
    assign column_ok = (32'(in_column) < COLUMN_COUNT);

    assign toggle    = (pressed_reg[row_reg][col_reg] == levels_reg[col_reg]);
    assign last_col  = (col_reg == COL_W'(SCAN_COLS - 1));
    assign last_slot = (slot_idx_reg == SLOT_W'(SLOT_COUNT - 1));
    assign cur_slot  = slot_reg[slot_idx_reg];
    assign slot_hit  = (cur_slot == code_reg);
    assign key_is_slot = (map_rd_data != CODE_EMPTY) && ((map_rd_data & MOD_FLAG) == CODE_EMPTY);
    // Press and release both stop at the first slot holding the code; otherwise the
    // walk runs to the last slot.
    assign slot_done = slot_hit || last_slot;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Key map lookup: one write on an in-range load transfer, one read per column.
    assign map_wr_en   = accept && (in_op == OP_LOAD) && row_ok && column_ok;
    assign map_wr_addr = ADDR_W'(32'(in_row) * COLUMN_COUNT + 32'(in_column));
    assign map_rd_addr = ADDR_W'(32'(row_reg) * COLUMN_COUNT + 32'(col_reg));

    kmhrb_ram #(
        .WIDTH  (CODE_W),
        .DEPTH  (MAP_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_key_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (in_code),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((in_op == OP_SCAN) && row_ok)
                    begin
                        state_next = ST_COL_CHECK;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_COL_CHECK:
            begin
                if (toggle)
                begin
                    state_next = ST_KEY_READ;
                end
                else if (last_col)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_KEY_READ:
            begin
                if (key_is_slot)
                begin
                    state_next = ST_SLOT_SCAN;
                end
                else if (last_col)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_COL_CHECK;
                end
            end
            ST_SLOT_SCAN:
            begin
                if (slot_done)
                begin
                    state_next = last_col ? ST_FINISH : ST_COL_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        pressed_next    = pressed_reg;
        slot_next       = slot_reg;
        modifier_next   = modifier_reg;
        row_next        = row_reg;
        levels_next     = levels_reg;
        col_next        = col_reg;
        code_next       = code_reg;
        down_next       = down_reg;
        slot_idx_next   = slot_idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        changed_next    = changed_reg;
        overflow_next   = overflow_reg;
        incons_next     = incons_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    row_next      = ROW_W'(in_row);
                    levels_next   = in_levels[SCAN_COLS-1:0];
                    col_next      = '0;
                    changed_next  = 1'b0;
                    overflow_next = 1'b0;
                    incons_next   = 1'b0;
                end
            end
            ST_COL_CHECK:
            begin
                if (toggle)
                begin
                    pressed_next[row_reg][col_reg] = !levels_reg[col_reg];
                    changed_next = 1'b1;
                    down_next    = !levels_reg[col_reg];
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_KEY_READ:
            begin
                code_next       = map_rd_data;
                slot_idx_next   = '0;
                free_found_next = 1'b0;
                if ((map_rd_data & MOD_FLAG) != CODE_EMPTY)
                begin
                    // Modifier indexes of 8 and up fall outside the byte.
                    if ((map_rd_data[3:0] & MOD_INDEX_MASK) < 4'd8)
                    begin
                        modifier_next[map_rd_data[2:0]] = down_reg;
                    end
                end
                if (!key_is_slot)
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_SLOT_SCAN:
            begin
                if (down_reg)
                begin
                    if (slot_hit)
                    begin
                        incons_next = 1'b1;
                    end
                    else if (last_slot)
                    begin
                        if (free_found_reg)
                        begin
                            slot_next[free_idx_reg] = code_reg;
                        end
                        else if (cur_slot == CODE_EMPTY)
                        begin
                            slot_next[slot_idx_reg] = code_reg;
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    else if ((cur_slot == CODE_EMPTY) && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = slot_idx_reg;
                    end
                end
                else
                begin
                    if (slot_hit)
                    begin
                        slot_next[slot_idx_reg] = CODE_EMPTY;
                    end
                    else if (last_slot)
                    begin
                        incons_next = 1'b1;
                    end
                end
                if (slot_done)
                begin
                    col_next = col_reg + 1'b1;
                end
                else
                begin
                    slot_idx_next = slot_idx_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next       = 1'b1;
                    m_tdata_next        = '0;
                    m_tdata_next[0]     = changed_reg;
                    m_tdata_next[8:1]   = modifier_reg;
                    for (int s = 0; s < OUT_SLOTS; s++)
                    begin
                        if (s < SLOT_COUNT)
                        begin
                            m_tdata_next[9 + 8*s +: 8] = slot_reg[s];
                        end
                    end
                    m_tdata_next[57]    = overflow_reg;
                    m_tdata_next[58]    = incons_reg;
                end
            end
            default:
            begin
                m_tdata_next = m_tdata_reg;
            end
        endcase
    end

    // Control and report state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            modifier_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            changed_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
            incons_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            col_reg        <= '0;
            slot_idx_reg   <= '0;
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                pressed_reg[r] <= '0;
            end
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                slot_reg[s] <= CODE_EMPTY;
            end
        end
        else
        begin
            state_reg      <= state_next;
            modifier_reg   <= modifier_next;
            m_tvalid_reg   <= m_tvalid_next;
            changed_reg    <= changed_next;
            overflow_reg   <= overflow_next;
            incons_reg     <= incons_next;
            free_found_reg <= free_found_next;
            col_reg        <= col_next;
            slot_idx_reg   <= slot_idx_next;
            pressed_reg    <= pressed_next;
            slot_reg       <= slot_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        levels_reg   <= levels_next;
        code_reg     <= code_next;
        down_reg     <= down_next;
        free_idx_reg <= free_idx_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== tb/tb_key_matrix_hid_report_builder.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the key matrix report builder.
//
// A queue of pending input items is filled by the stimulus process and fed to
// the slave stream by a clocked driver. Every accepted input transfer updates
// a local copy of the pressed map, key map, modifier byte and report slots,
// and the resulting report is appended to a store of expected reports. A
// clocked monitor compares every output transfer field by field against the
// oldest expected report.
module tb_key_matrix_hid_report_builder;
    import kmhrb_pkg::*;

    localparam int ROWS  = 6;
    localparam int COLS  = 19;
    localparam int SLOTS = 6;

    // The worst scan walks all columns and, for every changed key, a map
    // lookup plus all slots.
    localparam int DRAIN_CYCLES = 200;
    // Long receiver hold-off used to back the block up against its input.
    localparam int HOLD_CYCLES  = 300;
    // Cycles without any accepted transfer before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;

    // One input item as it travels on the slave stream.
    typedef struct packed {
        logic                      op;
        logic [ROW_FIELD_W-1:0]    row;
        logic [LEVEL_FIELD_W-1:0]  levels;
        logic [COLUMN_FIELD_W-1:0] col;
        logic [CODE_W-1:0]         code;
    } key_item_t;

    // Report fields, ordered so that the struct lines up with m_tdata[58:0].
    typedef struct packed {
        logic                             incons;
        logic                             overflow;
        logic [OUT_SLOTS-1:0][CODE_W-1:0] slot;
        logic [CODE_W-1:0]                modifiers;
        logic                             changed;
    } hid_report_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata from bit 0: row_index, column_levels, map_column, map_code, padding
    logic [39:0] s_tdata  = '0;
    // s_tuser: operation
    logic        s_tuser  = OP_LOAD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata from bit 0: report_changed, modifier_bits, slot_code_0..5,
    // rollover_overflow, inconsistency_seen, padding
    logic [63:0] m_tdata;

    // Local copy of the block's state, advanced once per accepted input transfer.
    logic [COLS-1:0]   key_down [ROWS];
    logic [CODE_W-1:0] code_map [ROWS][COLS];
    logic [CODE_W-1:0] mod_byte;
    logic [CODE_W-1:0] report_slots [SLOTS];
    hid_report_t       expected_reports [$];

    // Stimulus-side bookkeeping: which key map entries have been loaded and
    // which keys the already queued scans leave pressed. Scans never toggle
    // a key whose map entry was never written.
    logic [COLS-1:0]   map_loaded [ROWS];
    logic [COLS-1:0]   plan_down [ROWS];
    key_item_t         pending_items [$];
    key_item_t         offered_item;

    int send_idle_pct = 20;
    int recv_idle_pct = 46;
    int hold_at       = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int reports_seen  = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    key_matrix_hid_report_builder #(
        .ROW_COUNT    (ROWS),
        .COLUMN_COUNT (COLS),
        .SLOT_COUNT   (SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one key event to the modifier byte and the slots.
    function automatic void apply_code(input logic [CODE_W-1:0] code, input bit down,
                                       inout bit overflow, inout bit incons);
        logic [3:0] mod_index;
        int         open_slot;
        int         hit_slot;
        if (code == CODE_EMPTY)
            return;
        if ((code & MOD_FLAG) != CODE_EMPTY)
        begin
            // Only indexes 0..7 land inside the modifier byte.
            mod_index = code[3:0] & MOD_INDEX_MASK;
            if (mod_index < 4'd8)
                mod_byte[mod_index[2:0]] = down;
            return;
        end
        open_slot = SLOTS;
        hit_slot  = SLOTS;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (report_slots[s] == code && hit_slot == SLOTS)
                hit_slot = s;
            if (report_slots[s] == CODE_EMPTY && open_slot == SLOTS)
                open_slot = s;
        end
        if (down)
        begin
            if (hit_slot < SLOTS)
                incons = 1'b1;
            else if (open_slot == SLOTS)
                overflow = 1'b1;
            else
                report_slots[open_slot] = code;
        end
        else if (hit_slot < SLOTS)
            report_slots[hit_slot] = CODE_EMPTY;
        else
            incons = 1'b1;
    endfunction

    // Advances the local state by one accepted item and stores the report
    // that the block must send for it.
    function automatic void predict_report(input key_item_t item);
        hid_report_t rep;
        bit          changed;
        bit          overflow;
        bit          incons;
        changed  = 1'b0;
        overflow = 1'b0;
        incons   = 1'b0;
        if (item.op == OP_LOAD)
        begin
            if (item.row < ROWS && item.col < COLS)
                code_map[item.row][item.col] = item.code;
        end
        else if (item.row < ROWS)
        begin
            // A key changes when its stored pressed bit equals its level,
            // since a low level means pressed.
            for (int c = 0; c < COLS; c++)
            begin
                if (key_down[item.row][c] == item.levels[c])
                begin
                    key_down[item.row][c] = ~item.levels[c];
                    changed = 1'b1;
                    apply_code(code_map[item.row][c], !item.levels[c], overflow, incons);
                end
            end
        end
        rep.changed   = changed;
        rep.modifiers = mod_byte;
        for (int s = 0; s < OUT_SLOTS; s++)
            rep.slot[s] = report_slots[s];
        rep.overflow  = overflow;
        rep.incons    = incons;
        expected_reports.push_back(rep);
    endfunction

    function automatic key_item_t make_load(input int row, input int col, input int code);
        key_item_t item;
        item.op     = OP_LOAD;
        item.row    = ROW_FIELD_W'(row);
        item.levels = LEVEL_FIELD_W'($urandom);
        item.col    = COLUMN_FIELD_W'(col);
        item.code   = CODE_W'(code);
        return item;
    endfunction

    function automatic key_item_t make_scan(input int row, input int levels);
        key_item_t item;
        item.op     = OP_SCAN;
        item.row    = ROW_FIELD_W'(row);
        item.levels = LEVEL_FIELD_W'(levels);
        item.col    = COLUMN_FIELD_W'($urandom);
        item.code   = CODE_W'($urandom);
        return item;
    endfunction

    // Queues an item. Columns of a scanned row whose map entry is still
    // unloaded are forced high, which keeps them released.
    function automatic void push_item(input key_item_t item);
        if (item.op == OP_LOAD)
        begin
            if (item.row < ROWS && item.col < COLS)
                map_loaded[item.row][item.col] = 1'b1;
        end
        else if (item.row < ROWS)
        begin
            item.levels = item.levels | ~map_loaded[item.row];
            plan_down[item.row] = ~item.levels;
        end
        pending_items.push_back(item);
    endfunction

    // Empty codes, modifiers of every index, a narrow pool of ordinary codes
    // that produces duplicates, and now and then any ordinary code.
    function automatic logic [CODE_W-1:0] pick_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return CODE_EMPTY;
        if (roll < 35)
            return CODE_W'($urandom_range(128, 255));
        if (roll < 85)
            return CODE_W'($urandom_range(1, 20));
        return CODE_W'($urandom_range(1, 127));
    endfunction

    function automatic void random_load();
        int row;
        int col;
        row = ($urandom_range(0, 99) < 5) ? $urandom_range(ROWS, 7) : $urandom_range(0, ROWS - 1);
        col = ($urandom_range(0, 99) < 5) ? $urandom_range(COLS, 31) : $urandom_range(0, COLS - 1);
        push_item(make_load(row, col, pick_code()));
    endfunction

    // Mostly a few keys pressed or released relative to the current state,
    // held to a handful of keys overall so the slots churn; the rest are
    // whole-row noise, release-all and press-all rows, and rows out of range.
    function automatic void random_scan();
        int              roll;
        int              row;
        int              total;
        int              flips;
        int              c;
        logic [COLS-1:0] levels;
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            push_item(make_scan($urandom_range(ROWS, 7), $urandom));
            return;
        end
        row = $urandom_range(0, ROWS - 1);
        if (roll < 12)
            levels = COLS'($urandom);
        else if (roll < 18)
            levels = '1;
        else if (roll < 20)
            levels = '0;
        else
        begin
            levels = ~plan_down[row];
            total  = 0;
            for (int r = 0; r < ROWS; r++)
                total += $countones(plan_down[r]);
            flips = $urandom_range(0, 3);
            for (int i = 0; i < flips; i++)
            begin
                c = $urandom_range(0, COLS - 1);
                if (!levels[c])
                    levels[c] = 1'b1;
                else if (total < $urandom_range(3, 9))
                begin
                    levels[c] = 1'b0;
                    total++;
                end
            end
        end
        push_item(make_scan(row, levels));
    endfunction

    function automatic void queue_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 25)
                random_load();
            else
                random_scan();
        end
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [CODE_W-1:0] want,
                               input logic [CODE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Slave-side driver. Whenever the current transfer completes or the bus
    // is empty, the next pending item is offered unless the sender idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_LOAD;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_report(offered_item);
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered_item.op;
                    s_tdata  <= {5'b0, offered_item.code, offered_item.col,
                                 offered_item.levels, offered_item.row};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Master-side monitor and receiver. Each output transfer is checked
    // against the oldest expected report. The receiver idles at random and,
    // once in the final phase, holds off long enough for the block to fill
    // its output register and stop taking input transfers.
    always @(posedge clk or negedge rst_n)
    begin
        hid_report_t want;
        hid_report_t got;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    $error("report transfer with nothing expected: 0x%0h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    got  = hid_report_t'(m_tdata[58:0]);
                    check_field("report_changed", want.changed, got.changed);
                    check_field("modifier_bits", want.modifiers, got.modifiers);
                    for (int s = 0; s < OUT_SLOTS; s++)
                        check_field($sformatf("slot_code_%0d", s), want.slot[s], got.slot[s]);
                    check_field("rollover_overflow", want.overflow, got.overflow);
                    check_field("inconsistency_seen", want.incons, got.incons);
                end
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (!hold_done && hold_at > 0 && reports_seen >= hold_at)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when neither side completes a transfer for too long.
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
                quiet_cycles++;
            else
                quiet_cycles = 0;
        end
        $display("tb_key_matrix_hid_report_builder: FAIL");
        $finish;
    end

    initial
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            key_down[r]   = '0;
            map_loaded[r] = '0;
            plan_down[r]  = '0;
            for (int c = 0; c < COLS; c++)
                code_map[r][c] = CODE_EMPTY;
        end
        mod_byte = CODE_EMPTY;
        for (int s = 0; s < SLOTS; s++)
            report_slots[s] = CODE_EMPTY;

        // Row 0 gets two ordinary codes, a duplicate of the first, the largest
        // ordinary code, two modifiers in range, a modifier outside the byte and
        // an empty entry.
        push_item(make_load(0, 0, 8'h04));
        push_item(make_load(0, 1, 8'h05));
        push_item(make_load(0, 2, 8'h81));
        push_item(make_load(0, 3, 8'hFF));
        push_item(make_load(0, 4, CODE_EMPTY));
        push_item(make_load(0, 5, 8'h7F));
        push_item(make_load(0, 6, 8'h04));
        push_item(make_load(0, 18, 8'h87));
        // Loads outside the map are dropped.
        push_item(make_load(7, 0, 8'h11));
        push_item(make_load(0, 31, 8'h12));
        push_item(make_load(ROWS, COLS - 1, 8'h13));
        // Press everything loaded in row 0: the duplicate is flagged.
        push_item(make_scan(0, 0));
        // Scans of rows outside the matrix change nothing.
        push_item(make_scan(7, 0));
        push_item(make_scan(ROWS, 32'h7FFFF));
        // Release all: the second release of the shared code finds no slot.
        push_item(make_scan(0, 32'h7FFFF));
        // Eight ordinary keys on row 1 overflow six slots, and their release
        // flags the two that never got one.
        for (int c = 0; c < 8; c++)
            push_item(make_load(1, c, 8'h10 + c));
        push_item(make_scan(1, 0));
        push_item(make_scan(1, 32'h7FFFF));

        // Load the whole map so random scans can reach every key.
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                push_item(make_load(r, c, pick_code()));
        queue_random(80);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        send_idle_pct = 46;
        recv_idle_pct = 20;
        queue_random(90);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_at = reports_seen + 15;
        queue_random(100);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_key_matrix_hid_report_builder: PASS");
        else
            $display("tb_key_matrix_hid_report_builder: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kmhrb_pkg.sv
rtl/kmhrb_ram.sv
rtl/key_matrix_hid_report_builder.sv
tb/tb_key_matrix_hid_report_builder.sv
